### hdl/pjs_pkg.sv
// Shared types, codes and constants of the print job priority scheduler.
package pjs_pkg;

   localparam int DEFAULT_CAPACITY = 16;

   localparam int REQ_TYPE_W = 2;
   localparam int USER_W     = 8;
   localparam int IMP_W      = 3;
   localparam int PAGES_W    = 5;
   localparam int STATUS_W   = 2;
   localparam int KEY_W      = IMP_W + PAGES_W;

   // request codes
   localparam logic [REQ_TYPE_W-1:0] REQ_PUSH    = 2'd0;
   localparam logic [REQ_TYPE_W-1:0] REQ_REMOVE  = 2'd1;
   localparam logic [REQ_TYPE_W-1:0] REQ_RELEASE = 2'd2;

   // result status codes
   localparam logic [STATUS_W-1:0] ST_OK    = 2'd0;
   localparam logic [STATUS_W-1:0] ST_FULL  = 2'd1;
   localparam logic [STATUS_W-1:0] ST_EMPTY = 2'd2;

   typedef struct packed {
      logic [USER_W-1:0]  user_id;
      logic [IMP_W-1:0]   importance;
      logic [PAGES_W-1:0] pages;
   } job_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_SCAN,
      ST_DRAIN,
      ST_EMIT
   } state_type;

   // controller to datapath
   typedef struct packed {
      logic exec_single;  // push, remove or empty release: one result
      logic scan_init;    // start a release
      logic scan_step;    // issue one store read of the scan
      logic emit;         // hand out the best job of the finished pass
   } cmd_type;

   // datapath to controller
   typedef struct packed {
      logic count_zero;
      logic scan_last;    // read address at the oldest entry
      logic emit_last;    // the job about to be emitted is the final one
      logic out_free;     // result register can take a new transaction
   } stat_type;

   function automatic logic [KEY_W-1:0] prio_key(input job_type j);
      prio_key = {j.importance, j.pages};
   endfunction

endpackage

### hdl/pjs_channels.sv
// Request and result channel interfaces of the print job priority scheduler.
interface pjs_req_if;
   logic                            valid;
   logic                            ready;
   logic [pjs_pkg::REQ_TYPE_W-1:0]  req_type;
   logic [pjs_pkg::USER_W-1:0]      user_id;
   logic [pjs_pkg::IMP_W-1:0]       importance;
   logic [pjs_pkg::PAGES_W-1:0]     pages;

   modport source (output valid, req_type, user_id, importance, pages, input ready);
   modport sink   (input valid, req_type, user_id, importance, pages, output ready);
endinterface

interface pjs_rsp_if;
   logic                            valid;
   logic                            ready;
   logic [pjs_pkg::USER_W-1:0]      job_user;
   logic [pjs_pkg::IMP_W-1:0]       job_importance;
   logic [pjs_pkg::PAGES_W-1:0]     job_pages;
   logic [pjs_pkg::STATUS_W-1:0]    status;
   logic                            last;

   modport source (output valid, job_user, job_importance, job_pages, status, last,
                   input ready);
   modport sink   (input valid, job_user, job_importance, job_pages, status, last,
                   output ready);
endinterface

### hdl/print_job_priority_scheduler.sv
// Top level of the print job priority scheduler: controller plus datapath.
//
// Holds up to CAPACITY print jobs in push order in a single-port-read memory.
// Push appends a job (status full and dropped when the store is full), remove
// discards the newest job (status empty when there is none), release drains
// every held job highest importance first, then most pages, exact ties newest
// first, with last set on the final job. Request code three is swallowed with
// no result. A push, remove or empty release yields its single result in the
// output register the cycle after acceptance. A release of N jobs makes, for
// each emitted job, one full pass over all N held entries at one memory read
// per cycle (jobs already handed out are masked, not removed), then drains the
// read pipeline and emits the best job, waiting while the result side stalls.
// No request is taken while a release is running, nor while the result
// register is full and stalled.
// There is no clearing pass after reset; the store needs none.
module print_job_priority_scheduler #(
   parameter int CAPACITY = pjs_pkg::DEFAULT_CAPACITY
) (
   input  logic      clock,
   input  logic      reset,
   pjs_req_if.sink   req_chan,
   pjs_rsp_if.source rsp_chan
);
   import pjs_pkg::*;

   cmd_type  cmd;   // controller commands
   stat_type stat;  // datapath status

   // sequencing: idle, scan pass, read drain, emit
   pjs_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_chan.valid),
      .req_type  (req_chan.req_type),
      .req_ready (req_chan.ready),
      .stat      (stat),
      .cmd       (cmd)
   );

   // store, best-job search and result register
   pjs_datapath #(
      .CAPACITY (CAPACITY)
   ) u_datapath (
      .clock          (clock),
      .reset          (reset),
      .cmd            (cmd),
      .stat           (stat),
      .req_type       (req_chan.req_type),
      .user_id        (req_chan.user_id),
      .importance     (req_chan.importance),
      .pages          (req_chan.pages),
      .rsp_valid      (rsp_chan.valid),
      .rsp_ready      (rsp_chan.ready),
      .job_user       (rsp_chan.job_user),
      .job_importance (rsp_chan.job_importance),
      .job_pages      (rsp_chan.job_pages),
      .status         (rsp_chan.status),
      .last           (rsp_chan.last)
   );

endmodule

### hdl/pjs_ctrl.sv
// Controller state machine of the print job priority scheduler.
module pjs_ctrl (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_valid,
   input  logic [pjs_pkg::REQ_TYPE_W-1:0]  req_type,
   output logic                            req_ready,
   input  pjs_pkg::stat_type               stat,
   output pjs_pkg::cmd_type                cmd
);
   import pjs_pkg::*;

   state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in  = state_ff;
      cmd       = '0;
      req_ready = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            req_ready = stat.out_free;
            if (req_valid && stat.out_free) begin
               if (req_type inside {REQ_PUSH, REQ_REMOVE}) begin
                  cmd.exec_single = 1'b1;
               end else if (req_type == REQ_RELEASE) begin
                  if (stat.count_zero) begin
                     cmd.exec_single = 1'b1;
                  end else begin
                     cmd.scan_init = 1'b1;
                     state_in      = ST_SCAN;
                  end
               end
            end
         end
         ST_SCAN: begin
            cmd.scan_step = 1'b1;
            if (stat.scan_last) begin
               state_in = ST_DRAIN;
            end
         end
         ST_DRAIN: begin
            state_in = ST_EMIT;
         end
         ST_EMIT: begin
            if (stat.out_free) begin
               cmd.emit = 1'b1;
               state_in = stat.emit_last ? ST_IDLE : ST_SCAN;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

endmodule

### hdl/pjs_datapath.sv
// Datapath: job store memory, scan pipeline, best-job tracking and result register.
module pjs_datapath #(
   parameter int CAPACITY = pjs_pkg::DEFAULT_CAPACITY
) (
   input  logic                            clock,
   input  logic                            reset,
   input  pjs_pkg::cmd_type                cmd,
   output pjs_pkg::stat_type               stat,
   input  logic [pjs_pkg::REQ_TYPE_W-1:0]  req_type,
   input  logic [pjs_pkg::USER_W-1:0]      user_id,
   input  logic [pjs_pkg::IMP_W-1:0]       importance,
   input  logic [pjs_pkg::PAGES_W-1:0]     pages,
   output logic                            rsp_valid,
   input  logic                            rsp_ready,
   output logic [pjs_pkg::USER_W-1:0]      job_user,
   output logic [pjs_pkg::IMP_W-1:0]       job_importance,
   output logic [pjs_pkg::PAGES_W-1:0]     job_pages,
   output logic [pjs_pkg::STATUS_W-1:0]    status,
   output logic                            last
);
   import pjs_pkg::*;

   localparam int CNT_W = $clog2(CAPACITY + 1);
   localparam int IDX_W = $clog2(CAPACITY);
   localparam logic [CNT_W-1:0] CAP_CNT = CNT_W'(CAPACITY);

   job_type mem [CAPACITY];

   logic [CNT_W-1:0]    count_ff, count_in;
   logic [CNT_W-1:0]    emitted_ff, emitted_in;
   logic [CAPACITY-1:0] taken_ff, taken_in;
   logic [IDX_W-1:0]    idx_ff, idx_in;
   logic                rd_valid_ff, rd_valid_in;
   logic [IDX_W-1:0]    rd_idx_ff, rd_idx_in;
   job_type             rd_data_ff;
   logic                best_valid_ff, best_valid_in;
   logic [IDX_W-1:0]    best_idx_ff, best_idx_in;
   job_type             best_job_ff, best_job_in;
   logic                out_valid_ff, out_valid_in;
   job_type             out_job_ff, out_job_in;
   logic [STATUS_W-1:0] out_status_ff, out_status_in;
   logic                out_last_ff, out_last_in;

   logic             full;
   logic [CNT_W-1:0] count_m1;
   logic [CNT_W-1:0] emitted_p1;
   logic             push_ok;

   assign full       = (count_ff == CAP_CNT);
   assign count_m1   = count_ff - CNT_W'(1);
   assign emitted_p1 = emitted_ff + CNT_W'(1);
   assign push_ok    = cmd.exec_single && (req_type == REQ_PUSH) && !full;

   assign stat.count_zero = (count_ff == '0);
   assign stat.scan_last  = (idx_ff == '0);
   assign stat.emit_last  = (emitted_p1 == count_ff);
   assign stat.out_free   = !out_valid_ff || rsp_ready;

   // store: one write port for push, one registered read port for the scan
   always_ff @(posedge clock) begin
      if (push_ok) begin
         mem[count_ff[IDX_W-1:0]] <= '{user_id: user_id, importance: importance,
                                       pages: pages};
      end
   end

   always_ff @(posedge clock) begin
      rd_data_ff <= mem[idx_ff];
   end

   always_comb begin
      count_in      = count_ff;
      emitted_in    = emitted_ff;
      taken_in      = taken_ff;
      idx_in        = idx_ff;
      rd_valid_in   = 1'b0;
      rd_idx_in     = idx_ff;
      best_valid_in = best_valid_ff;
      best_idx_in   = best_idx_ff;
      best_job_in   = best_job_ff;
      out_valid_in  = out_valid_ff && !rsp_ready;
      out_job_in    = out_job_ff;
      out_status_in = out_status_ff;
      out_last_in   = out_last_ff;

      if (cmd.exec_single) begin
         out_valid_in = 1'b1;
         out_job_in   = '0;
         out_last_in  = 1'b1;
         case (req_type)
            REQ_PUSH: begin
               out_status_in = full ? ST_FULL : ST_OK;
               if (!full) begin
                  count_in = count_ff + CNT_W'(1);
               end
            end
            REQ_REMOVE: begin
               out_status_in = stat.count_zero ? ST_EMPTY : ST_OK;
               if (!stat.count_zero) begin
                  count_in = count_m1;
               end
            end
            default: begin
               out_status_in = ST_EMPTY;
            end
         endcase
      end

      if (cmd.scan_init) begin
         idx_in        = count_m1[IDX_W-1:0];
         best_valid_in = 1'b0;
         emitted_in    = '0;
         taken_in      = '0;
      end

      if (cmd.scan_step) begin
         rd_valid_in = 1'b1;
         idx_in      = idx_ff - IDX_W'(1);
      end

      // newest to oldest; strict compare keeps the newest of an exact tie
      if (rd_valid_ff && !taken_ff[rd_idx_ff] &&
          (!best_valid_ff || (prio_key(rd_data_ff) > prio_key(best_job_ff)))) begin
         best_valid_in = 1'b1;
         best_idx_in   = rd_idx_ff;
         best_job_in   = rd_data_ff;
      end

      if (cmd.emit) begin
         out_valid_in           = 1'b1;
         out_job_in             = best_job_ff;
         out_status_in          = ST_OK;
         out_last_in            = stat.emit_last;
         taken_in[best_idx_ff]  = 1'b1;
         emitted_in             = emitted_p1;
         best_valid_in          = 1'b0;
         idx_in                 = count_m1[IDX_W-1:0];
         if (stat.emit_last) begin
            count_in   = '0;
            taken_in   = '0;
            emitted_in = '0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff      <= '0;
         emitted_ff    <= '0;
         taken_ff      <= '0;
         rd_valid_ff   <= 1'b0;
         best_valid_ff <= 1'b0;
         out_valid_ff  <= 1'b0;
      end else begin
         count_ff      <= count_in;
         emitted_ff    <= emitted_in;
         taken_ff      <= taken_in;
         rd_valid_ff   <= rd_valid_in;
         best_valid_ff <= best_valid_in;
         out_valid_ff  <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      idx_ff        <= idx_in;
      rd_idx_ff     <= rd_idx_in;
      best_idx_ff   <= best_idx_in;
      best_job_ff   <= best_job_in;
      out_job_ff    <= out_job_in;
      out_status_ff <= out_status_in;
      out_last_ff   <= out_last_in;
   end

   assign rsp_valid      = out_valid_ff;
   assign job_user       = out_job_ff.user_id;
   assign job_importance = out_job_ff.importance;
   assign job_pages      = out_job_ff.pages;
   assign status         = out_status_ff;
   assign last           = out_last_ff;

endmodule

### hdl/pjs_checker.sv
// Port-level assertions for the print job priority scheduler, with bind.
module pjs_checker (
   input logic                            clock,
   input logic                            reset,
   input logic                            req_ready,
   input logic                            rsp_valid,
   input logic                            rsp_ready,
   input logic [pjs_pkg::USER_W-1:0]      job_user,
   input logic [pjs_pkg::IMP_W-1:0]       job_importance,
   input logic [pjs_pkg::PAGES_W-1:0]     job_pages,
   input logic [pjs_pkg::STATUS_W-1:0]    status,
   input logic                            last
);
   import pjs_pkg::*;

   // a full or empty report is a lone transaction with no job in it
   a_err_lone: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (status != ST_OK) |->
         last && (job_user == '0) && (job_importance == '0) && (job_pages == '0))
      else $error("error status without last or with job fields");

   // no request is taken while a release still has jobs to hand out
   a_release_busy: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !last |-> !req_ready)
      else $error("request taken during release");

   // nothing comes out straight after reset
   a_reset_quiet: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("result valid after reset");

   // stalled transaction holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=>
         rsp_valid && $stable(job_user) && $stable(job_importance) &&
         $stable(job_pages) && $stable(status) && $stable(last))
      else $error("stalled result changed");

endmodule

bind print_job_priority_scheduler pjs_checker u_pjs_checker (
   .clock          (clock),
   .reset          (reset),
   .req_ready      (req_chan.ready),
   .rsp_valid      (rsp_chan.valid),
   .rsp_ready      (rsp_chan.ready),
   .job_user       (rsp_chan.job_user),
   .job_importance (rsp_chan.job_importance),
   .job_pages      (rsp_chan.job_pages),
   .status         (rsp_chan.status),
   .last           (rsp_chan.last)
);

### test/tb_top.sv
// Self-checking testbench of the print job priority scheduler.
`timescale 1ns / 100ps

module tb_top;
   import pjs_pkg::*;

   localparam int CAPACITY     = DEFAULT_CAPACITY;
   localparam int RANDOM_ITEMS = 290;
   localparam int CYCLE_LIMIT  = 400000;   // watchdog bound on the whole run
   localparam int DRAIN_CYCLES = 40;       // quiet spell after the last awaited transaction
   localparam int IDLE_PCT     = 28;
   localparam int PLAN_LEN     = 21;
   localparam int REPORT_CAP   = 50;       // mismatches printed before going quiet

   // request code with no meaning: swallowed by the block
   localparam logic [REQ_TYPE_W-1:0] REQ_UNUSED = 2'd3;

   // one result transaction as seen on the rsp channel
   typedef struct packed {
      job_type             job;
      logic [STATUS_W-1:0] status;
      logic                last;
   } sched_rsp_type;

   // a row of the directed plan; typed rows carry their status by hand
   typedef struct {
      logic [REQ_TYPE_W-1:0] op;
      logic [USER_W-1:0]     user;
      logic [IMP_W-1:0]      imp;
      logic [PAGES_W-1:0]    pages;
      int                    reps;
      bit                    typed;
      logic [STATUS_W-1:0]   status;
   } plan_row_type;

   logic clock = 1'b0;
   logic reset = 1'b1;

   pjs_req_if req_bus ();
   pjs_rsp_if rsp_bus ();

   print_job_priority_scheduler #(
      .CAPACITY (CAPACITY)
   ) uut (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_bus),
      .rsp_chan (rsp_bus)
   );

   // 12 ns period
   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   // ---------------------------------------------------------------------
   // Shadow of the job store, kept in push order like the hardware.
   // ---------------------------------------------------------------------
   job_type       shadow_jobs [CAPACITY];
   int            shadow_count = 0;
   sched_rsp_type awaited_rsp [$];

   int  errors      = 0;
   int  cycles      = 0;
   int  n_accepted  = 0;
   int  n_results   = 0;
   int  n_releases  = 0;
   int  n_full      = 0;
   int  n_empty     = 0;
   bit  calm        = 1'b0;   // both sides run flat out while set

   plan_row_type plan [PLAN_LEN];

   // Works out the result transactions one request causes and updates the shadow.
   function automatic void schedule_request(input logic [REQ_TYPE_W-1:0] op,
                                            input job_type j);
      sched_rsp_type r;
      job_type       pick;
      int            best;
      r = '0;
      r.last = 1'b1;
      case (op)
         REQ_PUSH: begin
            if (shadow_count >= CAPACITY) begin
               r.status = ST_FULL;
            end else begin
               shadow_jobs[shadow_count] = j;
               shadow_count++;
               r.status = ST_OK;
            end
            awaited_rsp.push_back(r);
         end
         REQ_REMOVE: begin
            if (shadow_count == 0) begin
               r.status = ST_EMPTY;
            end else begin
               shadow_count--;
               r.status = ST_OK;
            end
            awaited_rsp.push_back(r);
         end
         REQ_RELEASE: begin
            if (shadow_count == 0) begin
               r.status = ST_EMPTY;
               awaited_rsp.push_back(r);
            end
            while (shadow_count > 0) begin
               // newest to oldest, strictly greater wins so ties stay with the newest
               best = shadow_count - 1;
               for (int i = shadow_count - 2; i >= 0; i--) begin
                  if ({shadow_jobs[i].importance, shadow_jobs[i].pages} >
                      {shadow_jobs[best].importance, shadow_jobs[best].pages})
                     best = i;
               end
               pick = shadow_jobs[best];
               for (int i = best; i < shadow_count - 1; i++)
                  shadow_jobs[i] = shadow_jobs[i + 1];
               shadow_count--;
               r.job    = pick;
               r.status = ST_OK;
               r.last   = (shadow_count == 0);
               awaited_rsp.push_back(r);
            end
         end
         default: ;   // unused code: no transaction, no change
      endcase
   endfunction

   task automatic report_mismatch(input string what, input int expd, input int got);
      errors++;
      if (errors <= REPORT_CAP)
         $display("%0t ns: mismatch on %s, expected %0d got %0d", $time, what, expd, got);
   endtask

   function automatic plan_row_type mk_row(input logic [REQ_TYPE_W-1:0] op,
                                           input logic [USER_W-1:0] user,
                                           input logic [IMP_W-1:0] imp,
                                           input logic [PAGES_W-1:0] pages,
                                           input int reps, input bit typed,
                                           input logic [STATUS_W-1:0] status);
      plan_row_type p;
      p.op     = op;
      p.user   = user;
      p.imp    = imp;
      p.pages  = pages;
      p.reps   = reps;
      p.typed  = typed;
      p.status = status;
      return p;
   endfunction

   // ---------------------------------------------------------------------
   // Request driver: changes at the falling edge, acceptance seen at the
   // rising edge. Entered and left just after a falling edge.
   // ---------------------------------------------------------------------
   task automatic send_request(input logic [REQ_TYPE_W-1:0] op, input job_type j,
                               input bit typed, input logic [STATUS_W-1:0] status);
      sched_rsp_type hand;
      while (!calm && $urandom_range(99) < IDLE_PCT) begin
         req_bus.valid = 1'b0;
         @(negedge clock);
      end
      req_bus.valid      = 1'b1;
      req_bus.req_type   = op;
      req_bus.user_id    = j.user_id;
      req_bus.importance = j.importance;
      req_bus.pages      = j.pages;
      do @(posedge clock); while (!req_bus.ready);
      schedule_request(op, j);
      if (typed) begin
         // shadow state moves as usual; the expectation comes from the plan
         hand        = '0;
         hand.status = status;
         hand.last   = 1'b1;
         void'(awaited_rsp.pop_back());
         awaited_rsp.push_back(hand);
      end
      if (op != REQ_UNUSED)
         n_accepted++;
      if (op == REQ_RELEASE)
         n_releases++;
      @(negedge clock);
   endtask

   function automatic job_type random_job(input bit narrow);
      job_type j;
      j.user_id = USER_W'($urandom_range(0, 255));
      if (narrow) begin
         // few distinct keys, so exact ties are common
         j.importance = IMP_W'($urandom_range(1, 2));
         j.pages      = PAGES_W'($urandom_range(1, 3));
      end else begin
         j.importance = ($urandom_range(0, 9) == 0) ? IMP_W'($urandom_range(0, 7))
                                                    : IMP_W'($urandom_range(1, 5));
         j.pages      = ($urandom_range(0, 9) == 0) ? PAGES_W'($urandom_range(0, 31))
                                                    : PAGES_W'($urandom_range(1, 20));
      end
      return j;
   endfunction

   // ---------------------------------------------------------------------
   // Result side: random back-pressure, checks against the oldest expectation.
   // ---------------------------------------------------------------------
   initial rsp_bus.ready = 1'b0;

   always @(negedge clock)
      rsp_bus.ready <= calm || ($urandom_range(99) >= IDLE_PCT);

   always @(posedge clock) begin
      sched_rsp_type want;
      if (!reset && rsp_bus.valid && rsp_bus.ready) begin
         n_results++;
         if (awaited_rsp.size() == 0) begin
            report_mismatch("unexpected result transaction", 0, 1);
         end else begin
            want = awaited_rsp.pop_front();
            if (rsp_bus.status === ST_FULL)
               n_full++;
            if (rsp_bus.status === ST_EMPTY)
               n_empty++;
            if (rsp_bus.job_user !== want.job.user_id)
               report_mismatch("job_user", int'(want.job.user_id),
                               int'(rsp_bus.job_user));
            if (rsp_bus.job_importance !== want.job.importance)
               report_mismatch("job_importance", int'(want.job.importance),
                               int'(rsp_bus.job_importance));
            if (rsp_bus.job_pages !== want.job.pages)
               report_mismatch("job_pages", int'(want.job.pages),
                               int'(rsp_bus.job_pages));
            if (rsp_bus.status !== want.status)
               report_mismatch("status", int'(want.status), int'(rsp_bus.status));
            if (rsp_bus.last !== want.last)
               report_mismatch("last", int'(want.last), int'(rsp_bus.last));
         end
      end
   end

   // watchdog
   always @(posedge clock) begin
      cycles++;
      if (cycles > CYCLE_LIMIT) begin
         $display("Timed out after %0d cycles, %0d transactions still awaited",
                  cycles, awaited_rsp.size());
         $display("TB_ERROR");
         $finish;
      end
   end

   // ---------------------------------------------------------------------
   // Stimulus
   // ---------------------------------------------------------------------
   initial begin
      job_type j;
      int      fill;
      int      sent;
      bit      narrow;

      req_bus.valid      = 1'b0;
      req_bus.req_type   = REQ_PUSH;
      req_bus.user_id    = '0;
      req_bus.importance = '0;
      req_bus.pages      = '0;

      // directed plan: empty store corners, field extremes, unused code,
      // exact ties, full store with a dropped push, release of a full store
      plan[0]  = mk_row(REQ_RELEASE, 8'h00, 3'd0, 5'd0,  1,  1'b1, ST_EMPTY);
      plan[1]  = mk_row(REQ_REMOVE,  8'h00, 3'd0, 5'd0,  1,  1'b1, ST_EMPTY);
      plan[2]  = mk_row(REQ_UNUSED,  8'hFF, 3'd7, 5'd31, 1,  1'b0, ST_OK);
      plan[3]  = mk_row(REQ_PUSH,    8'h00, 3'd1, 5'd1,  1,  1'b1, ST_OK);
      plan[4]  = mk_row(REQ_PUSH,    8'hFF, 3'd5, 5'd20, 1,  1'b1, ST_OK);
      plan[5]  = mk_row(REQ_PUSH,    8'h5A, 3'd0, 5'd0,  1,  1'b1, ST_OK);
      plan[6]  = mk_row(REQ_PUSH,    8'hA5, 3'd7, 5'd31, 1,  1'b1, ST_OK);
      plan[7]  = mk_row(REQ_REMOVE,  8'h00, 3'd0, 5'd0,  1,  1'b1, ST_OK);
      plan[8]  = mk_row(REQ_PUSH,    8'h11, 3'd5, 5'd20, 1,  1'b0, ST_OK);
      plan[9]  = mk_row(REQ_PUSH,    8'h12, 3'd5, 5'd19, 1,  1'b0, ST_OK);
      plan[10] = mk_row(REQ_PUSH,    8'h13, 3'd4, 5'd20, 1,  1'b0, ST_OK);
      plan[11] = mk_row(REQ_RELEASE, 8'h00, 3'd0, 5'd0,  1,  1'b0, ST_OK);
      plan[12] = mk_row(REQ_PUSH,    8'h80, 3'd3, 5'd7,  16, 1'b0, ST_OK);
      plan[13] = mk_row(REQ_PUSH,    8'hFF, 3'd5, 5'd20, 1,  1'b1, ST_FULL);
      plan[14] = mk_row(REQ_UNUSED,  8'h00, 3'd0, 5'd0,  1,  1'b0, ST_OK);
      plan[15] = mk_row(REQ_RELEASE, 8'h00, 3'd0, 5'd0,  1,  1'b0, ST_OK);
      plan[16] = mk_row(REQ_PUSH,    8'h21, 3'd2, 5'd3,  1,  1'b0, ST_OK);
      plan[17] = mk_row(REQ_PUSH,    8'h22, 3'd2, 5'd4,  1,  1'b0, ST_OK);
      plan[18] = mk_row(REQ_REMOVE,  8'h00, 3'd0, 5'd0,  1,  1'b1, ST_OK);
      plan[19] = mk_row(REQ_RELEASE, 8'h00, 3'd0, 5'd0,  1,  1'b0, ST_OK);
      plan[20] = mk_row(REQ_RELEASE, 8'h00, 3'd0, 5'd0,  1,  1'b1, ST_EMPTY);

      // synchronous reset, released at a falling edge
      repeat (12) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      foreach (plan[r]) begin
         for (int k = 0; k < plan[r].reps; k++) begin
            j.user_id    = plan[r].user + USER_W'(k);
            j.importance = plan[r].imp;
            j.pages      = plan[r].pages;
            send_request(plan[r].op, j, plan[r].typed, plan[r].status);
         end
      end

      // random part: fill runs with random jobs, the odd remove or stray code,
      // then mostly a release; some runs overshoot the capacity
      sent = 0;
      while (sent < RANDOM_ITEMS) begin
         calm   = (sent >= 120 && sent < 200);   // long stretch without idling
         narrow = ($urandom_range(0, 2) == 0);
         fill   = ($urandom_range(0, 3) == 0) ? $urandom_range(14, 19)
                                              : $urandom_range(1, 10);
         for (int k = 0; k < fill; k++) begin
            j = random_job(narrow);
            if ($urandom_range(0, 99) < 4) begin
               send_request(REQ_UNUSED, j, 1'b0, ST_OK);
            end else if ($urandom_range(0, 99) < 12) begin
               send_request(REQ_REMOVE, j, 1'b0, ST_OK);
               sent++;
            end else begin
               send_request(REQ_PUSH, j, 1'b0, ST_OK);
               sent++;
            end
         end
         if ($urandom_range(0, 99) < 85) begin
            send_request(REQ_RELEASE, random_job(1'b0), 1'b0, ST_OK);
            sent++;
            if ($urandom_range(0, 99) < 8) begin
               // second release finds the store empty
               send_request(REQ_RELEASE, random_job(1'b0), 1'b0, ST_OK);
               sent++;
            end
         end
      end
      calm          = 1'b0;
      req_bus.valid = 1'b0;

      // let everything drain, then a quiet spell to catch strays
      while (awaited_rsp.size() != 0)
         @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      $display("Ran %0d requests including %0d releases; %0d result transactions checked,",
               n_accepted, n_releases, n_results);
      $display("of which %0d full-store drops and %0d empty-store replies, %0d mismatches.",
               n_full, n_empty, errors);
      if (errors == 0) begin
         $display("TB_OK");
      end else begin
         $display("TB_ERROR");
      end
      $finish;
   end

endmodule
